FILE: sv/csofs_pkg.sv
package csofs_pkg;

	localparam int PRIME_BITS = 30;
	localparam int WIN_BITS = 31;
	localparam int MEMBER_BITS = 3;
	localparam int NUM_MEMBERS = 6;
	localparam logic [WIN_BITS-1:0] WINDOW_RESET = 31'd19200000;

	typedef struct packed {
		logic [PRIME_BITS-1:0] prime;
		logic [PRIME_BITS-1:0] base_residue;
		logic [PRIME_BITS-1:0] primorial_residue;
	} in_item_t;

	typedef struct packed {
		logic [PRIME_BITS-1:0]  offset;
		logic [MEMBER_BITS-1:0] member;
		logic                   in_window;
		logic                   no_inverse;
		logic                   last;
	} out_item_t;

	// Queue entry: the item plus the front's classification of it.
	typedef struct packed {
		in_item_t item;
		logic     zero_mod;
	} q_entry_t;

	// Handshake between the front queue and the back engine.
	typedef struct packed {
		logic valid;
		logic pop;
	} q_ctrl_t;

endpackage

FILE: sv/csofs_front.sv
module csofs_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  csofs_pkg::in_item_t request,
	output csofs_pkg::q_entry_t head,
	output logic               head_valid,
	input  logic               pop
);
	import csofs_pkg::*;

	q_entry_t  entry_q [2];
	logic      wr_ptr_q;
	logic      rd_ptr_q;
	logic [1:0] count_q;
	logic      push;

	assign busy       = (count_q == 2'd2);
	assign push       = start && !busy;
	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q].item     <= request;
			entry_q[wr_ptr_q].zero_mod <= (request.prime == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end
endmodule

FILE: sv/csofs_back.sv
module csofs_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  csofs_pkg::q_entry_t            head,
	input  logic                           head_valid,
	output logic                           pop,
	input  logic [csofs_pkg::WIN_BITS-1:0] window,
	output logic                           strobe,
	output csofs_pkg::out_item_t           result
);
	import csofs_pkg::*;

	localparam int W = PRIME_BITS;
	localparam int CW = $clog2(W + 1);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_REDUCE = 4'd1;
	localparam logic [3:0] S_CHK    = 4'd2;
	localparam logic [3:0] S_UP     = 4'd3;
	localparam logic [3:0] S_DOWN   = 4'd4;
	localparam logic [3:0] S_FIX    = 4'd5;
	localparam logic [3:0] S_DBL2   = 4'd6;
	localparam logic [3:0] S_DBL4   = 4'd7;
	localparam logic [3:0] S_MUL    = 4'd8;
	localparam logic [3:0] S_EMIT   = 4'd9;

	logic [3:0]            state_q;
	logic [CW-1:0]         cnt_q;
	logic [MEMBER_BITS-1:0] member_q;
	logic [W-1:0]          p_q, res_q, prim_q, bsh_q, psh_q;
	logic [W-1:0]          r_q, nr_q, inv_q, inv2_q, inv4_q, acc_q, k_q;
	logic signed [W+1:0]   t_q, nt_q, dt_q;
	logic [W:0]            d_q;
	logic [CW-1:0]         sh_q;
	logic                  bad_q;
	logic                  strobe_q;
	out_item_t             result_q;

	logic [W:0]            rem_b, rem_p, dbl, a2, sum;
	logic [W+1:0]          d2;
	logic [W:0]            r_new;
	logic signed [W+1:0]   t_new, t_fix;
	logic [W-1:0]          d_step;
	logic [W:0]            k_next;

	assign pop    = (state_q == S_IDLE) && head_valid;
	assign strobe = strobe_q;
	assign result = result_q;

	always_comb begin
		rem_b = {res_q, bsh_q[W-1]};
		if (rem_b >= {1'b0, p_q})
			rem_b = rem_b - {1'b0, p_q};
		rem_p = {prim_q, psh_q[W-1]};
		if (rem_p >= {1'b0, p_q})
			rem_p = rem_p - {1'b0, p_q};

		d2 = {d_q, 1'b0};

		r_new = {1'b0, r_q};
		t_new = t_q;
		if (d_q <= {1'b0, r_q}) begin
			r_new = {1'b0, r_q} - d_q;
			t_new = t_q - dt_q;
		end

		t_fix = t_q;
		if (t_fix < 0)
			t_fix = t_fix + $signed({2'b00, p_q});
		if (t_fix >= $signed({2'b00, p_q}))
			t_fix = t_fix - $signed({2'b00, p_q});

		dbl = (state_q == S_DBL2) ? {inv_q, 1'b0} : {inv2_q, 1'b0};
		if (dbl >= {1'b0, p_q})
			dbl = dbl - {1'b0, p_q};

		a2 = {acc_q, 1'b0};
		if (a2 >= {1'b0, p_q})
			a2 = a2 - {1'b0, p_q};
		sum = a2 + (bsh_q[W-1] ? {1'b0, inv_q} : '0);
		if (sum >= {1'b0, p_q})
			sum = sum - {1'b0, p_q};

		// Odd members follow a gap of four, even members a gap of two.
		d_step = member_q[0] ? inv2_q : inv4_q;
		if (k_q < d_step)
			k_next = {1'b0, k_q} + {1'b0, p_q} - {1'b0, d_step};
		else
			k_next = {1'b0, k_q} - {1'b0, d_step};
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				p_q    <= head.item.prime;
				bsh_q  <= head.item.base_residue;
				psh_q  <= head.item.primorial_residue;
				res_q  <= '0;
				prim_q <= '0;
				bad_q  <= 1'b1;
				inv2_q <= '0;
				inv4_q <= '0;
				k_q    <= '0;
			end
			S_REDUCE: begin
				res_q  <= rem_b[W-1:0];
				prim_q <= rem_p[W-1:0];
				bsh_q  <= {bsh_q[W-2:0], 1'b0};
				psh_q  <= {psh_q[W-2:0], 1'b0};
				r_q    <= p_q;
				nr_q   <= rem_p[W-1:0];
				t_q    <= '0;
				nt_q   <= (W+2)'(1);
			end
			S_CHK: begin
				d_q  <= {1'b0, nr_q};
				dt_q <= nt_q;
				sh_q <= '0;
			end
			S_UP: begin
				if (d2 <= {2'b00, r_q}) begin
					d_q  <= d2[W:0];
					dt_q <= dt_q <<< 1;
					sh_q <= sh_q + CW'(1);
				end
			end
			S_DOWN: begin
				if (sh_q == '0) begin
					r_q  <= nr_q;
					nr_q <= r_new[W-1:0];
					t_q  <= nt_q;
					nt_q <= t_new;
				end else begin
					r_q  <= r_new[W-1:0];
					t_q  <= t_new;
					d_q  <= d_q >> 1;
					dt_q <= dt_q >>> 1;
					sh_q <= sh_q - CW'(1);
				end
			end
			S_FIX: begin
				bad_q <= (r_q > W'(1));
				inv_q <= (r_q > W'(1)) ? '0 : t_fix[W-1:0];
				bsh_q <= res_q;
				acc_q <= '0;
			end
			S_DBL2: inv2_q <= dbl[W-1:0];
			S_DBL4: inv4_q <= dbl[W-1:0];
			S_MUL: begin
				acc_q <= sum[W-1:0];
				bsh_q <= {bsh_q[W-2:0], 1'b0};
				k_q   <= p_q - sum[W-1:0];
			end
			S_EMIT: k_q <= k_next[W-1:0];
			default: ;
		endcase
		result_q.offset     <= k_q;
		result_q.member     <= member_q;
		result_q.in_window  <= ({1'b0, k_q} < window);
		result_q.no_inverse <= bad_q;
		result_q.last       <= (member_q == MEMBER_BITS'(NUM_MEMBERS - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			member_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == S_EMIT);
			unique case (state_q)
				S_IDLE: begin
					cnt_q    <= '0;
					member_q <= '0;
					if (head_valid)
						state_q <= head.zero_mod ? S_EMIT : S_REDUCE;
				end
				S_REDUCE: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(W - 1))
						state_q <= S_CHK;
				end
				S_CHK:  state_q <= (nr_q == '0) ? S_FIX : S_UP;
				S_UP: begin
					if (!(d2 <= {2'b00, r_q}))
						state_q <= S_DOWN;
				end
				S_DOWN: begin
					if (sh_q == '0)
						state_q <= S_CHK;
				end
				S_FIX:  state_q <= S_DBL2;
				S_DBL2: state_q <= S_DBL4;
				S_DBL4: begin
					cnt_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(W - 1))
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					member_q <= member_q + MEMBER_BITS'(1);
					if (member_q == MEMBER_BITS'(NUM_MEMBERS - 1))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/constellation_sieve_offsets.sv
// Steps: the front queue registers each item, then the back engine runs residue reduction,
// the shift-subtract extended Euclid loop, inverse scaling in the FIX, DBL2 and DBL4
// states, a modular multiply and the six results, one item per cycle, each shown in the
// cycle after its step. A zero modulus goes straight to the results. The back engine takes
// a new item only after its last result; the two-entry queue holds items meanwhile.
// Reset clears the queue and sequencer and loads the default sieve window.
module constellation_sieve_offsets (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  csofs_pkg::in_item_t            request,
	input  logic                           window_we,
	input  logic [csofs_pkg::WIN_BITS-1:0] window_data,
	output logic                           strobe,
	output csofs_pkg::out_item_t           result
);
	import csofs_pkg::*;

	// Sieve window: the user writes it only while idle; the block does not enforce it.
	logic [WIN_BITS-1:0] window_q;

	// The front accepts each item into a two-entry queue and marks a zero
	// modulus, which the back engine handles without any arithmetic.
	q_entry_t head;
	q_ctrl_t  qc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (window_we) begin
			window_q <= window_data;
		end
	end

	csofs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.head       (head),
		.head_valid (qc.valid),
		.pop        (qc.pop)
	);

	// The back engine reduces the residues, inverts the primorial residue,
	// forms k and steps through the six pattern members.
	csofs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (qc.valid),
		.pop        (qc.pop),
		.window     (window_q),
		.strobe     (strobe),
		.result     (result)
	);
endmodule

FILE: tb/constellation_sieve_offsets_tb.sv
`timescale 1ns / 1ps

module constellation_sieve_offsets_tb;
	import csofs_pkg::*;

	// Timing of the run. The watchdog limit allows for the slowest Euclid loop on every
	// item with a wide margin.
	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 12;
	localparam int RANDOM_ITEMS = 170;
	localparam int DRAIN_CYCLES = 400;
	localparam int IDLE_CYCLES  = 500;

	// Stimulus kinds used by the random part.
	typedef enum int {
		KIND_PRIME,
		KIND_COMPOSITE,
		KIND_WIDE,
		KIND_TINY
	} stim_kind_e;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t request;
	logic window_we;
	logic [WIN_BITS-1:0] window_data;
	logic strobe;
	out_item_t result;

	// The predictor keeps its own copy of the sieve window.
	logic [WIN_BITS-1:0] window_model;

	// Offsets that the block still owes, oldest first.
	out_item_t pending_offsets[$];

	int mismatches;
	int offsets_checked;
	int items_sent;
	int no_inverse_seen;
	int window_hits;

	constellation_sieve_offsets dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.window_we  (window_we),
		.window_data(window_data),
		.strobe     (strobe),
		.result     (result)
	);

	initial clk = 1'b0;
	always #CLK_HALF clk = ~clk;

	// Modular inverse by the extended Euclidean algorithm. The flag is set when
	// the residue shares a factor with the modulus, and the inverse is then zero.
	function automatic longint unsigned modular_inverse(longint unsigned a,
			longint unsigned m, output bit none_exists);
		longint t, nt, r, nr, q, x;
		t = 0;
		nt = 1;
		r = m;
		nr = a;
		while (nr != 0) begin
			q = r / nr;
			x = t - q * nt;
			t = nt;
			nt = x;
			x = r - q * nr;
			r = nr;
			nr = x;
		end
		if (r > 1) begin
			none_exists = 1'b1;
			return 0;
		end
		none_exists = 1'b0;
		if (t < 0)
			t += m;
		return longint'(t) % m;
	endfunction

	// Works out the six pattern offsets for one accepted item and queues them.
	task automatic predict_offsets(input in_item_t it);
		longint unsigned p, base, prim, inv, inv2, inv4, k, step;
		longint unsigned offs[NUM_MEMBERS];
		bit none_exists;
		out_item_t o;
		p = it.prime;
		none_exists = 1'b1;
		if (p == 0) begin
			// A zero modulus skips all arithmetic; every offset is zero.
			foreach (offs[i])
				offs[i] = 0;
		end else begin
			base = it.base_residue % p;
			prim = it.primorial_residue % p;
			inv = modular_inverse(prim, p, none_exists);
			inv2 = inv << 1;
			if (inv2 >= p)
				inv2 -= p;
			inv4 = inv2 << 1;
			if (inv4 >= p)
				inv4 -= p;
			k = p - (base * inv) % p;
			offs[0] = k;
			// The gaps alternate 4 and 2 times the inverse, modulo p.
			for (int i = 1; i < NUM_MEMBERS; i++) begin
				step = (i & 1) ? inv4 : inv2;
				if (k < step)
					k += p;
				k -= step;
				offs[i] = k;
			end
		end
		for (int i = 0; i < NUM_MEMBERS; i++) begin
			o.offset = offs[i][PRIME_BITS-1:0];
			o.member = i[MEMBER_BITS-1:0];
			o.in_window = offs[i] < window_model;
			o.no_inverse = none_exists;
			o.last = i == NUM_MEMBERS - 1;
			pending_offsets.push_back(o);
		end
	endtask

	// Every offset shown by the block is compared with the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && strobe) begin
			offsets_checked++;
			if (result.no_inverse)
				no_inverse_seen++;
			if (result.in_window)
				window_hits++;
			if (pending_offsets.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected offset %0d member %0d",
						result.offset, result.member);
			end else begin
				want = pending_offsets.pop_front();
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"ERROR: offset mismatch: expected off=%0d mem=%0d ",
							"win=%0d noinv=%0d last=%0d, got off=%0d mem=%0d ",
							"win=%0d noinv=%0d last=%0d"},
							want.offset, want.member, want.in_window,
							want.no_inverse, want.last, result.offset,
							result.member, result.in_window, result.no_inverse,
							result.last);
				end
			end
		end
	end

	// Hands one item to the block. Start is raised at a falling edge; busy only
	// moves at rising edges, so it is checked at falling edges and the item is
	// taken at the first rising edge that follows a low busy. Start stays high
	// so that the next item of a burst can follow; the caller lowers it.
	task automatic send_item(input in_item_t it);
		request <= it;
		start <= 1'b1;
		while (busy)
			@(negedge clk);
		@(posedge clk);
		predict_offsets(it);
		items_sent++;
		@(negedge clk);
	endtask

	// The block is idle once every offset has arrived and it has had time to
	// settle; only then is the window register touched.
	task automatic wait_drained();
		while (pending_offsets.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_window(input logic [WIN_BITS-1:0] value);
		window_we <= 1'b1;
		window_data <= value;
		@(posedge clk);
		window_model = value;
		@(negedge clk);
		window_we <= 1'b0;
	endtask

	// A small random odd prime, found by trial division.
	function automatic logic [PRIME_BITS-1:0] random_prime(input int unsigned top);
		int unsigned n;
		bit is_prime;
		forever begin
			n = $urandom_range(top, 3) | 1;
			is_prime = 1'b1;
			for (int unsigned d = 3; d * d <= n; d += 2)
				if (n % d == 0) begin
					is_prime = 1'b0;
					break;
				end
			if (is_prime)
				return n[PRIME_BITS-1:0];
		end
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		stim_kind_e kind;
		int unsigned p;
		kind = stim_kind_e'($urandom_range(3, 0));
		case (kind)
			KIND_PRIME: begin
				// Well-formed work: a true prime with reduced residues.
				p = 32'(random_prime($urandom_range(1, 0) ? 1000 : 30000000));
				it.prime = p[PRIME_BITS-1:0];
				it.base_residue = PRIME_BITS'($urandom_range(p - 1, 0));
				it.primorial_residue = PRIME_BITS'($urandom_range(p - 1, 0));
			end
			KIND_COMPOSITE: begin
				// Small moduli, not always composite, that often share a factor with the residue.
				p = $urandom_range(5000, 4);
				it.prime = p[PRIME_BITS-1:0];
				it.base_residue = PRIME_BITS'($urandom_range(p - 1, 0));
				it.primorial_residue = PRIME_BITS'(($urandom_range(40, 1) * 6) % p);
			end
			KIND_WIDE: begin
				// Full-width noise, including unreduced residues.
				it.prime = PRIME_BITS'($urandom);
				it.base_residue = PRIME_BITS'($urandom);
				it.primorial_residue = PRIME_BITS'($urandom);
			end
			default: begin
				it.prime = PRIME_BITS'($urandom_range(4, 0));
				it.base_residue = PRIME_BITS'($urandom_range(8, 0));
				it.primorial_residue = PRIME_BITS'($urandom_range(8, 0));
			end
		endcase
		return it;
	endfunction

	// Directed rows. Where the answer is plain at a glance it is typed in and
	// also checked against the predictor through the same scoreboard.
	typedef struct {
		in_item_t  item;
		bit        known;
		logic [PRIME_BITS-1:0] first_offset;
		logic      no_inverse;
	} directed_row_t;

	directed_row_t directed_rows[] = '{
		// Zero modulus: every offset is zero and flagged as no inverse.
		'{'{30'd0, 30'd5, 30'd7}, 1, 30'd0, 1'b1},
		// Modulus one: every offset is one.
		'{'{30'd1, 30'h3FFFFFFF, 30'h3FFFFFFF}, 1, 30'd1, 1'b0},
		// Zero primorial residue has no inverse: offsets equal p.
		'{'{30'd7, 30'd3, 30'd0}, 1, 30'd7, 1'b1},
		// Primorial one, base zero: k equals p.
		'{'{30'd11, 30'd0, 30'd1}, 1, 30'd11, 1'b0},
		'{'{30'd3, 30'd2, 30'd2}, 0, 30'd0, 1'b0},
		'{'{30'd13, 30'd12, 30'd5}, 0, 30'd0, 1'b0},
		// Composite modulus with a shared factor.
		'{'{30'd15, 30'd4, 30'd6}, 1, 30'd15, 1'b1},
		'{'{30'd15, 30'd4, 30'd7}, 0, 30'd0, 1'b0},
		// Unreduced residues.
		'{'{30'd17, 30'h3FFFFFFF, 30'd40}, 0, 30'd0, 1'b0},
		'{'{30'd19, 30'd100, 30'd19}, 1, 30'd19, 1'b1},
		// Large field values, then p = 2 and a modulus just above the reset window.
		'{'{30'h3FFFFFFF, 30'h3FFFFFFE, 30'h3FFFFFFE}, 0, 30'd0, 1'b0},
		'{'{30'd1073741789, 30'd123456789, 30'd987654321}, 0, 30'd0, 1'b0},
		'{'{30'h3FFFFFFF, 30'h2AAAAAAA, 30'h15555555}, 0, 30'd0, 1'b0},
		'{'{30'd2, 30'd1, 30'd1}, 0, 30'd0, 1'b0},
		'{'{30'd19200013, 30'd5, 30'd30030}, 0, 30'd0, 1'b0}
	};

	initial begin
		int burst;
		int first;
		start = 1'b0;
		request = '0;
		window_we = 1'b0;
		window_data = '0;
		window_model = WINDOW_RESET;
		mismatches = 0;
		offsets_checked = 0;
		items_sent = 0;
		no_inverse_seen = 0;
		window_hits = 0;
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part at the reset window.
		foreach (directed_rows[r]) begin
			send_item(directed_rows[r].item);
			if (directed_rows[r].known) begin
				// The member 0 prediction of this item is six entries from the end.
				first = pending_offsets.size() - NUM_MEMBERS;
				if (pending_offsets[first].offset !== directed_rows[r].first_offset ||
						pending_offsets[first].no_inverse !== directed_rows[r].no_inverse) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: directed row %0d predicts %0d, table says %0d",
							r, pending_offsets[first].offset, directed_rows[r].first_offset);
				end
			end
		end
		start <= 1'b0;

		// Random part, run through several windows including the extremes.
		for (int phase = 0; phase < 5; phase++) begin
			wait_drained();
			case (phase)
				0: write_window(31'd0);
				1: write_window(31'h7FFFFFFF);
				2: write_window(31'd1);
				3: write_window(31'd500);
				default: write_window(31'h40000000);
			endcase
			for (int n = 0; n < RANDOM_ITEMS / 5;) begin
				burst = $urandom_range(6, 1);
				for (int b = 0; b < burst && n < RANDOM_ITEMS / 5; b++, n++)
					send_item(random_item());
				if ($urandom_range(1, 0)) begin
					start <= 1'b0;
					repeat ($urandom_range(IDLE_CYCLES, 1)) @(negedge clk);
				end
			end
			start <= 1'b0;
		end

		wait_drained();
		$display("Checked %0d offsets from %0d items; %0d without an inverse, %0d in window.",
			offsets_checked, items_sent, no_inverse_seen, window_hits);
		if (mismatches == 0 && pending_offsets.size() == 0)
			$display("constellation_sieve_offsets verification clean");
		else
			$display("constellation_sieve_offsets verification failed");
		$finish;
	end

	// Watchdog: a generous bound on the slowest run.
	initial begin
		#100ms;
		$display("ERROR: timeout");
		$display("constellation_sieve_offsets verification failed");
		$finish;
	end

endmodule
